// ===== rtl/pbn_pkg.sv =====
package pbn_pkg;

    localparam int TEX_ADDR_BITS   = 16;
    localparam int COORD_FRAC_BITS = 16;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;

    localparam int DIM_W    = 13;
    localparam int STRIDE_W = 17;
    localparam int BPT_W    = 3;
    localparam int T_W      = 50;
    localparam int ROW_T_W  = DIM_W + STRIDE_W;
    localparam int COL_T_W  = DIM_W + BPT_W;
    localparam int SUM_W    = ROW_T_W + 1;

    localparam int Q_DEPTH = 16;

    typedef struct packed {
        logic [63:0]         x_lo;
        logic [63:0]         x_hi;
        logic [63:0]         z_lo;
        logic [63:0]         z_hi;
        logic [DIM_W-1:0]    tex_width;
        logic [DIM_W-1:0]    tex_height;
        logic [STRIDE_W-1:0] row_stride;
        logic [BPT_W-1:0]    bytes_per_texel;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        x_lo:            64'h0000_0001_0000_0000,
        x_hi:            64'h0,
        z_lo:            64'h0,
        z_hi:            64'h0000_0000_0001_0000,
        tex_width:       13'd1,
        tex_height:      13'd1,
        row_stride:      17'd1,
        bytes_per_texel: 3'd1
    };

    typedef struct packed {
        logic               qry;
        logic [15:0]        ld_addr;
        logic [7:0]         ld_byte;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } in_item_t;

    typedef struct packed {
        logic        vld;
        logic        qry;
        logic [15:0] ld_addr;
        logic [7:0]  ld_byte;
    } meta_t;

    typedef struct packed {
        meta_t              meta;
        logic [15:0]        u16;
        logic [15:0]        v16;
        logic [ROW_T_W-1:0] row_term;
        logic [COL_T_W-1:0] col_term;
    } xf_out_t;

    typedef struct packed {
        logic        vld;
        logic [15:0] u16;
        logic [15:0] v16;
        logic [15:0] texel_addr;
        logic        err;
        logic [7:0]  texel;
    } st_out_t;

    typedef struct packed {
        logic [15:0] normal_x;
        logic [14:0] normal_y;
        logic [15:0] normal_z;
        logic [15:0] height_val;
        logic [15:0] u_coord;
        logic [15:0] v_coord;
        logic [15:0] texel_addr;
        logic        addr_error;
    } res_t;

    typedef logic [255:0][15:0] tab16_t;
    typedef logic [255:0][14:0] tab15_t;
    typedef logic [255:0][2:0]  mod5_tab_t;

    function automatic logic [15:0] norm_comp(input longint unsigned a,
                                              input longint unsigned s);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned t;
        longint unsigned tt;
        longint unsigned mid;
        longint unsigned o;
        lo = 0;
        hi = 32768;
        t  = 2 * a * 32768;
        tt = t * t;
        for (int k = 0; k < 17; k++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                o   = 2 * mid - 1;
                if (o * o * s <= tt) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
        end
        return (lo > 32767) ? 16'd32767 : 16'(lo);
    endfunction

    function automatic longint unsigned abs_d(input int c);
        return (c >= 128) ? longint'(2 * c - 255) : longint'(255 - 2 * c);
    endfunction

    function automatic tab16_t build_nx();
        tab16_t          tab;
        longint unsigned ad;
        logic [15:0]     n;
        for (int c = 0; c < 256; c++) begin
            ad = abs_d(c);
            n  = norm_comp(ad, 2 * ad * ad + 65025);
            tab[c] = (c >= 128) ? n : 16'(~n + 16'd1);
        end
        return tab;
    endfunction

    function automatic tab15_t build_ny();
        tab15_t          tab;
        longint unsigned ad;
        logic [15:0]     n;
        for (int c = 0; c < 256; c++) begin
            ad = abs_d(c);
            n  = norm_comp(255, 2 * ad * ad + 65025);
            tab[c] = n[14:0];
        end
        return tab;
    endfunction

    function automatic tab16_t build_hv();
        tab16_t          tab;
        longint unsigned ad;
        longint unsigned h;
        for (int c = 0; c < 256; c++) begin
            ad = abs_d(c);
            h  = (ad * 65536 + 255) / 510;
            if (c >= 128) begin
                tab[c] = (h > 32767) ? 16'd32767 : 16'(h);
            end else begin
                tab[c] = 16'(65536 - h);
            end
        end
        return tab;
    endfunction

    function automatic mod5_tab_t build_mod5();
        mod5_tab_t tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = 3'(i % 5);
        end
        return tab;
    endfunction

    localparam tab16_t    NX_TAB   = build_nx();
    localparam tab15_t    NY_TAB   = build_ny();
    localparam tab16_t    HV_TAB   = build_hv();
    localparam mod5_tab_t MOD5_TAB = build_mod5();

endpackage

// ===== rtl/pbn_regs.sv =====
module pbn_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pbn_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pbn_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pbn_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output pbn_pkg::cfg_t                  cfg
);
    import pbn_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_X_LO   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_X_HI   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_Z_LO   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_Z_HI   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_BPT    = 3'd7;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_X_LO:   cfg_next.x_lo            = pwdata;
                REG_X_HI:   cfg_next.x_hi            = pwdata;
                REG_Z_LO:   cfg_next.z_lo            = pwdata;
                REG_Z_HI:   cfg_next.z_hi            = pwdata;
                REG_WIDTH:  cfg_next.tex_width       = pwdata[DIM_W-1:0];
                REG_HEIGHT: cfg_next.tex_height      = pwdata[DIM_W-1:0];
                REG_STRIDE: cfg_next.row_stride      = pwdata[STRIDE_W-1:0];
                REG_BPT:    cfg_next.bytes_per_texel = pwdata[BPT_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_X_LO:   prdata = cfg_reg.x_lo;
            REG_X_HI:   prdata = cfg_reg.x_hi;
            REG_Z_LO:   prdata = cfg_reg.z_lo;
            REG_Z_HI:   prdata = cfg_reg.z_hi;
            REG_WIDTH:  prdata = APB_DATA_W'(cfg_reg.tex_width);
            REG_HEIGHT: prdata = APB_DATA_W'(cfg_reg.tex_height);
            REG_STRIDE: prdata = APB_DATA_W'(cfg_reg.row_stride);
            REG_BPT:    prdata = APB_DATA_W'(cfg_reg.bytes_per_texel);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/pbn_xform.sv =====
module pbn_xform (
    input  logic              aclk,
    input  logic              aresetn,
    input  pbn_pkg::cfg_t     cfg,
    input  logic              in_vld,
    input  pbn_pkg::in_item_t in_item,
    output pbn_pkg::xf_out_t  xo
);
    import pbn_pkg::*;

    localparam int F    = COORD_FRAC_BITS;
    localparam int FS   = (F >= 16) ? F - 16 : 0;
    localparam int RS   = (F < 16) ? 16 - F : 0;
    localparam int TF_W = T_W + FS;
    localparam int HR_W = TF_W - F - 2;
    localparam int HI_W = ((HR_W + 3) / 4) * 4;
    localparam int NIB  = HI_W / 4;
    localparam int X_W  = F + 3;
    localparam int M_W  = X_W + 1;
    localparam int P_W  = X_W + M_W;
    localparam int SH   = X_W + 3;
    localparam longint unsigned M5_L = ((64'd1 << SH) + 64'd4) / 64'd5;
    localparam logic [M_W-1:0] M5 = M_W'(M5_L);
    localparam int UC_W = F + DIM_W + 1;
    localparam logic [UC_W-1:0] HALF = UC_W'(1) << (F - 1);
    localparam int NST  = 8;

    // wrapped fraction of t/20 split as {(t >> F+2) mod 5, bits F+1..2}
    function automatic logic [X_W-1:0] wrap_split(input logic signed [T_W-1:0] t);
        logic signed [TF_W-1:0] tf;
        logic signed [TF_W-1:0] hs;
        logic [HI_W-1:0]        hi;
        logic [7:0]             nsum;
        tf = (TF_W'(t) <<< FS) >>> RS;
        hs = tf >>> (F + 2);
        hi = hs[HI_W-1:0];
        nsum = hi[HI_W-1] ? 8'd4 : 8'd0;
        for (int k = 0; k < NIB; k++) begin
            nsum = nsum + 8'(hi[4*k +: 4]);
        end
        return {MOD5_TAB[nsum], tf[F+1:2]};
    endfunction

    meta_t meta_reg  [1:NST];
    meta_t meta_next [1:NST];

    logic signed [31:0]  px_reg, py_reg, pz_reg;
    logic signed [63:0]  prod_reg  [0:5];
    logic signed [63:0]  prod_next [0:5];
    logic signed [T_W-1:0] xa_reg, xb_reg, za_reg, zb_reg;
    logic signed [T_W-1:0] xa_next, xb_next, za_next, zb_next;
    logic signed [T_W-1:0] tx_reg, tz_reg, tx_next, tz_next;
    logic [X_W-1:0]      wx_reg, wz_reg, wx_next, wz_next;
    logic [P_W-1:0]      ux_prod_reg, vz_prod_reg, ux_prod_next, vz_prod_next;
    logic [F-1:0]        u_reg, v_reg, u_next, v_next;
    logic [UC_W-1:0]     ucp_reg, vrp_reg, ucp_next, vrp_next;
    logic [DIM_W-1:0]    span_u, span_v;
    logic [UC_W-1:0]     col_sum, row_sum;
    logic [DIM_W-1:0]    col, row;
    logic [F+15:0]       ue, ve;
    logic [15:0]         u16_reg, v16_reg, u16_next, v16_next;
    logic [ROW_T_W-1:0]  rt_reg, rt_next;
    logic [COL_T_W-1:0]  ct_reg, ct_next;

    assign span_u = (cfg.tex_width != '0) ? cfg.tex_width - 1'b1 : '0;
    assign span_v = (cfg.tex_height != '0) ? cfg.tex_height - 1'b1 : '0;

    always_comb begin
        meta_next[1] = '{vld: in_vld, qry: in_item.qry,
                         ld_addr: in_item.ld_addr, ld_byte: in_item.ld_byte};
        for (int k = 2; k <= NST; k++) begin
            meta_next[k] = meta_reg[k-1];
        end
    end

    always_comb begin
        prod_next[0] = $signed(cfg.x_lo[31:0])  * px_reg;
        prod_next[1] = $signed(cfg.x_lo[63:32]) * py_reg;
        prod_next[2] = $signed(cfg.x_hi[31:0])  * pz_reg;
        prod_next[3] = $signed(cfg.z_lo[31:0])  * px_reg;
        prod_next[4] = $signed(cfg.z_lo[63:32]) * py_reg;
        prod_next[5] = $signed(cfg.z_hi[31:0])  * pz_reg;

        xa_next = T_W'(prod_reg[0] >>> 16) + T_W'(prod_reg[1] >>> 16);
        xb_next = T_W'(prod_reg[2] >>> 16) + T_W'($signed(cfg.x_hi[63:32]));
        za_next = T_W'(prod_reg[3] >>> 16) + T_W'(prod_reg[4] >>> 16);
        zb_next = T_W'(prod_reg[5] >>> 16) + T_W'($signed(cfg.z_hi[63:32]));

        tx_next = xa_reg + xb_reg;
        tz_next = za_reg + zb_reg;

        wx_next = wrap_split(tx_reg);
        wz_next = wrap_split(tz_reg);

        ux_prod_next = P_W'(wx_reg) * P_W'(M5);
        vz_prod_next = P_W'(wz_reg) * P_W'(M5);

        u_next   = ux_prod_reg[SH+F-1:SH];
        v_next   = vz_prod_reg[SH+F-1:SH];
        ucp_next = UC_W'(u_next) * UC_W'(span_u);
        vrp_next = UC_W'(v_next) * UC_W'(span_v);

        col_sum  = ucp_reg + HALF;
        row_sum  = vrp_reg + HALF;
        col      = col_sum[F+DIM_W-1:F];
        row      = row_sum[F+DIM_W-1:F];
        rt_next  = ROW_T_W'(row) * ROW_T_W'(cfg.row_stride);
        ct_next  = COL_T_W'(col) * COL_T_W'(cfg.bytes_per_texel);
        ue       = (F + 16)'(u_reg) << 16;
        ve       = (F + 16)'(v_reg) << 16;
        u16_next = ue[F+15:F];
        v16_next = ve[F+15:F];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= NST; k++) begin
                meta_reg[k] <= '0;
            end
        end else begin
            for (int k = 1; k <= NST; k++) begin
                meta_reg[k] <= meta_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        px_reg <= in_item.px;
        py_reg <= in_item.py;
        pz_reg <= in_item.pz;
        for (int k = 0; k < 6; k++) begin
            prod_reg[k] <= prod_next[k];
        end
        xa_reg      <= xa_next;
        xb_reg      <= xb_next;
        za_reg      <= za_next;
        zb_reg      <= zb_next;
        tx_reg      <= tx_next;
        tz_reg      <= tz_next;
        wx_reg      <= wx_next;
        wz_reg      <= wz_next;
        ux_prod_reg <= ux_prod_next;
        vz_prod_reg <= vz_prod_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        ucp_reg     <= ucp_next;
        vrp_reg     <= vrp_next;
        u16_reg     <= u16_next;
        v16_reg     <= v16_next;
        rt_reg      <= rt_next;
        ct_reg      <= ct_next;
    end

    assign xo = '{meta: meta_reg[NST], u16: u16_reg, v16: v16_reg,
                  row_term: rt_reg, col_term: ct_reg};

endmodule

// ===== rtl/pbn_tex_store.sv =====
module pbn_tex_store (
    input  logic             aclk,
    input  logic             aresetn,
    input  pbn_pkg::xf_out_t xi,
    output pbn_pkg::st_out_t so
);
    import pbn_pkg::*;

    localparam int TA    = TEX_ADDR_BITS;
    localparam int DEPTH = 1 << TA;

    logic [7:0]       store_mem [DEPTH];
    logic [SUM_W-1:0] addr_sum;
    logic             err;
    logic [TA-1:0]    rd_idx;
    logic [TA-1:0]    ld_idx;
    logic             wr_en;
    logic             rd_en;
    logic [7:0]       rd_data_reg;
    logic             vld_reg, vld_next;
    logic [15:0]      u16_reg, v16_reg, taddr_reg, taddr_next;
    logic             err_reg;

    assign addr_sum   = SUM_W'(xi.row_term) + SUM_W'(xi.col_term);
    assign err        = (addr_sum >> TA) != '0;
    assign rd_idx     = err ? '1 : addr_sum[TA-1:0];
    assign ld_idx     = TA'(32'(xi.meta.ld_addr));
    assign wr_en      = xi.meta.vld && !xi.meta.qry;
    assign rd_en      = xi.meta.vld && xi.meta.qry;
    assign vld_next   = rd_en;
    assign taddr_next = 16'(32'(rd_idx));

    // loads and queries reach this port in item order, at most one per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[ld_idx] <= xi.meta.ld_byte;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        u16_reg   <= xi.u16;
        v16_reg   <= xi.v16;
        taddr_reg <= taddr_next;
        err_reg   <= err;
    end

    assign so = '{vld: vld_reg, u16: u16_reg, v16: v16_reg, texel_addr: taddr_reg,
                  err: err_reg, texel: err_reg ? 8'd0 : rd_data_reg};

endmodule

// ===== rtl/pbn_out_fifo.sv =====
module pbn_out_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  pbn_pkg::res_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output pbn_pkg::res_t rd_data
);
    import pbn_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    res_t           fifo_mem [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             pop;

    assign rd_valid = count_reg != '0;
    assign rd_data  = fifo_mem[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W + 1)'(wr_en) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fifo_mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/planar_bump_normal.sv =====
// one item accepted per cycle, loads and queries alike, while s_ready is high
// a query's result can be taken once it has passed through eight transform
// stages, the texture store read and the result queue
// up to 16 queries may be outstanding; the 16-entry result queue sets that figure
// reset is synchronous and active low; it clears control state and loads the
// register defaults; texture store contents stay undefined until written
module planar_bump_normal (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pbn_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pbn_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pbn_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [15:0]                    s_load_addr,
    input  logic [7:0]                     s_load_byte,
    input  logic signed [31:0]             s_point_x,
    input  logic signed [31:0]             s_point_y,
    input  logic signed [31:0]             s_point_z,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [15:0]             m_normal_x,
    output logic [14:0]                    m_normal_y,
    output logic signed [15:0]             m_normal_z,
    output logic signed [15:0]             m_height_val,
    output logic [15:0]                    m_u_coord,
    output logic [15:0]                    m_v_coord,
    output logic [15:0]                    m_texel_addr,
    output logic                           m_addr_error
);
    import pbn_pkg::*;

    localparam int CRD_W = $clog2(Q_DEPTH + 1);

    cfg_t             cfg;
    in_item_t         in_item;
    xf_out_t          xo;
    st_out_t          so;
    res_t             res_in;
    res_t             res_out;
    logic             s_accept;
    logic             m_accept;
    logic [CRD_W-1:0] credit_cnt_reg, credit_cnt_next;

    pbn_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_item = '{qry: s_req_type, ld_addr: s_load_addr, ld_byte: s_load_byte,
                       px: s_point_x, py: s_point_y, pz: s_point_z};

    pbn_xform u_xform (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .in_vld  (s_accept),
        .in_item (in_item),
        .xo      (xo)
    );

    pbn_tex_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .xi      (xo),
        .so      (so)
    );

    always_comb begin
        res_in.normal_x   = NX_TAB[so.texel];
        res_in.normal_y   = NY_TAB[so.texel];
        res_in.normal_z   = NX_TAB[so.texel];
        res_in.height_val = HV_TAB[so.texel];
        res_in.u_coord    = so.u16;
        res_in.v_coord    = so.v16;
        res_in.texel_addr = so.texel_addr;
        res_in.addr_error = so.err;
    end

    pbn_out_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (so.vld),
        .wr_data  (res_in),
        .rd_valid (m_valid),
        .rd_ready (m_ready),
        .rd_data  (res_out)
    );

    // queries in flight plus queued results never exceed the queue depth
    assign s_ready  = credit_cnt_reg < CRD_W'(Q_DEPTH);
    assign s_accept = s_valid && s_ready;
    assign m_accept = m_valid && m_ready;

    always_comb begin
        credit_cnt_next = credit_cnt_reg + CRD_W'(s_accept && s_req_type)
                          - CRD_W'(m_accept);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_cnt_reg <= '0;
        end else begin
            credit_cnt_reg <= credit_cnt_next;
        end
    end

    assign m_normal_x   = res_out.normal_x;
    assign m_normal_y   = res_out.normal_y;
    assign m_normal_z   = res_out.normal_z;
    assign m_height_val = res_out.height_val;
    assign m_u_coord    = res_out.u_coord;
    assign m_v_coord    = res_out.v_coord;
    assign m_texel_addr = res_out.texel_addr;
    assign m_addr_error = res_out.addr_error;

endmodule

// ===== rtl/planar_bump_normal_chk.sv =====
module planar_bump_normal_chk (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           pready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic signed [15:0]             m_normal_x,
    input logic signed [15:0]             m_normal_z,
    input logic signed [15:0]             m_height_val,
    input logic [15:0]                    m_texel_addr,
    input logic                           m_addr_error
);

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_normal_x)
                                && $stable(m_height_val) && $stable(m_texel_addr))
        else $error("stalled result item changed");

    a_nz_equals_nx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_normal_z == m_normal_x)
        else $error("normal z differs from normal x");

    a_err_height: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_addr_error |-> m_height_val == 16'sh8000 && m_normal_x[15])
        else $error("out of range address did not read as byte zero");

endmodule

bind planar_bump_normal planar_bump_normal_chk u_chk (.*);
